>>> src/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page frame allocator: shared definitions
// Default sizes, result status codes and the word search result type.
// ----------------------------------------------------------------------------
package bpfa_pkg;

	localparam int WORD_BITS        = 32;
	localparam int BIT_W            = 5;
	localparam int MAX_FRAMES_DEF   = 32768;
	localparam int PAGE_BYTES_DEF   = 4096;
	localparam int FRAMES_RESET     = 32768;

	localparam logic [2:0] ST_ALLOCATED     = 3'd0;
	localparam logic [2:0] ST_NONE_FREE     = 3'd1;
	localparam logic [2:0] ST_FREED         = 3'd2;
	localparam logic [2:0] ST_NOT_ALLOCATED = 3'd3;
	localparam logic [2:0] ST_OUT_OF_RANGE  = 3'd4;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} find_t;

endpackage

>>> src/bpfa_ram.sv
// ----------------------------------------------------------------------------
// Bitmap page frame allocator: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bpfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/bpfa_find.sv
// ----------------------------------------------------------------------------
// Bitmap page frame allocator: word search
// Finds the lowest clear bit of one bitmap word within a window of positions.
// ----------------------------------------------------------------------------
module bpfa_find (
	input  logic [bpfa_pkg::WORD_BITS-1:0] word,
	input  logic [bpfa_pkg::BIT_W-1:0]     lo,
	input  logic                           hi_all,
	input  logic [bpfa_pkg::BIT_W-1:0]     hi,
	output bpfa_pkg::find_t                res
);

	logic [bpfa_pkg::WORD_BITS-1:0] low_mask;
	logic [bpfa_pkg::WORD_BITS-1:0] high_mask;
	logic [bpfa_pkg::WORD_BITS-1:0] cand;

	// Positions below lo and at or above hi (unless the whole word counts) are excluded.
	assign low_mask  = {bpfa_pkg::WORD_BITS{1'b1}} << lo;
	assign high_mask = hi_all ? {bpfa_pkg::WORD_BITS{1'b1}}
		: ~({bpfa_pkg::WORD_BITS{1'b1}} << hi);
	assign cand      = ~word & low_mask & high_mask;

	always_comb begin
		res.found = |cand;
		res.pos   = '0;
		for (int i = bpfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				res.pos = bpfa_pkg::BIT_W'(i);
			end
		end
	end

endmodule

>>> src/bitmap_page_frame_allocator_core.sv
// Allocate: one bitmap word per cycle from the hint word until a clear bit is found or the
// limit is reached; the scan is skipped when the hint is at the limit.
// Free: one bitmap read and write-back; an out-of-range index goes straight to the result.
// One item at a time: the next is taken the cycle after the result loads.
// After reset the bitmap is cleared one word per cycle (all MAP_WORDS words, 1024 at the
// default size) and no item is taken until that pass is done.
// ----------------------------------------------------------------------------
// Bitmap page frame allocator core
// Used-bit bitmap in RAM with a lowest-free hint, allocate and free requests.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_core #(
	parameter int MAX_FRAMES = bpfa_pkg::MAX_FRAMES_DEF,
	parameter int PAGE_BYTES = bpfa_pkg::PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: frames_in_use
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	// Requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] release_address
	input  logic [0:0]  s_tuser,   // [0] func
	// Results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [2:0] status, [29:3] frame_address,
	                               // [45:30] used_count, [61:46] free_count
);

	localparam int MAP_WORDS = (MAX_FRAMES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
	localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
	localparam int FW        = AW + bpfa_pkg::BIT_W;
	localparam int HW        = FW + 1;
	localparam int CW        = HW > 16 ? HW : 16;
	localparam int PBL       = $clog2(PAGE_BYTES);
	localparam int IW        = 32 - PBL;
	localparam int XW        = IW > CW ? IW : CW;
	localparam int LIMIT_RST = bpfa_pkg::FRAMES_RESET > MAX_FRAMES ? MAX_FRAMES
		: bpfa_pkg::FRAMES_RESET;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_FREE  = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] word_q;
	logic          first_q;
	logic [FW-1:0] frame_q;
	logic [HW-1:0] hint_q;
	logic [15:0]   used_q;
	logic [CW-1:0] limit_q;
	logic [2:0]    status_q;
	logic [26:0]   faddr_q;

	logic          m_valid_q;
	logic [2:0]    m_status_q;
	logic [26:0]   m_faddr_q;
	logic [15:0]   m_used_q;
	logic [15:0]   m_free_q;

	logic                            accept;
	logic                            req_free;
	logic [IW-1:0]                   idx;
	logic                            idx_oor;
	logic                            hint_end;
	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [bpfa_pkg::WORD_BITS-1:0]  ram_wdata;
	logic                            ram_re;
	logic [AW-1:0]                   ram_raddr;
	logic [bpfa_pkg::WORD_BITS-1:0]  ram_rdata;
	logic [CW-1:0]                   base;
	logic [CW-1:0]                   rem;
	logic                            hi_all;
	logic                            scan_end;
	bpfa_pkg::find_t                 fres;
	logic [FW-1:0]                   found_frame;
	logic [bpfa_pkg::WORD_BITS-1:0]  alloc_bit;
	logic [bpfa_pkg::WORD_BITS-1:0]  free_bit;
	logic                            free_hit;
	logic [FW+PBL-1:0]               faddr_wide;
	logic [CW-1:0]                   used_ext;
	logic [CW-1:0]                   free_wide;
	logic                            out_load;
	logic [CW-1:0]                   cfg_ext;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign req_free = s_tuser[0];
	assign idx      = s_tdata[31:PBL];
	assign idx_oor  = XW'(idx) >= XW'(limit_q);
	assign hint_end = CW'(hint_q) >= limit_q;

	// Window of the current word: from the hint on the first word, up to the limit.
	assign base     = CW'({word_q, {bpfa_pkg::BIT_W{1'b0}}});
	assign rem      = limit_q - base;
	assign hi_all   = rem[CW-1:bpfa_pkg::BIT_W] != '0;
	// Limit falls inside or right at the end of this word: nothing further to read.
	assign scan_end = !hi_all || (rem == CW'(bpfa_pkg::WORD_BITS));

	bpfa_find u_find (
		.word   (ram_rdata),
		.lo     (first_q ? hint_q[bpfa_pkg::BIT_W-1:0] : '0),
		.hi_all (hi_all),
		.hi     (rem[bpfa_pkg::BIT_W-1:0]),
		.res    (fres)
	);

	assign found_frame = {word_q, fres.pos};
	assign alloc_bit   = bpfa_pkg::WORD_BITS'(1) << fres.pos;
	assign free_bit    = bpfa_pkg::WORD_BITS'(1) << frame_q[bpfa_pkg::BIT_W-1:0];
	assign free_hit    = (ram_rdata & free_bit) != '0;
	assign faddr_wide  = {found_frame, {PBL{1'b0}}};

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = word_q + AW'(1);
		if (state_q == S_IDLE) begin
			ram_re    = accept;
			ram_raddr = req_free ? idx[FW-1:bpfa_pkg::BIT_W]
				: hint_q[FW-1:bpfa_pkg::BIT_W];
		end else if (state_q == S_SCAN) begin
			ram_re    = !fres.found && !scan_end;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = ram_rdata | alloc_bit;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_SCAN: begin
				ram_we    = fres.found;
			end
			S_FREE: begin
				ram_we    = free_hit;
				ram_waddr = frame_q[FW-1:bpfa_pkg::BIT_W];
				ram_wdata = ram_rdata & ~free_bit;
			end
			default: begin
				ram_we    = 1'b0;
			end
		endcase
	end

	bpfa_ram #(
		.WIDTH (bpfa_pkg::WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cfg_ext = CW'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= CW'(LIMIT_RST);
		end else if (cfg_we) begin
			limit_q <= (cfg_ext > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : cfg_ext;
		end
	end

	assign out_load = (state_q == S_RESP) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			hint_q   <= '0;
			used_q   <= '0;
			word_q   <= '0;
			first_q  <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (req_free) begin
							word_q <= idx[FW-1:bpfa_pkg::BIT_W];
							state_q <= idx_oor ? S_RESP : S_FREE;
						end else begin
							word_q  <= hint_q[FW-1:bpfa_pkg::BIT_W];
							first_q <= 1'b1;
							state_q <= hint_end ? S_RESP : S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (fres.found) begin
						used_q  <= used_q + 16'd1;
						hint_q  <= HW'(found_frame) + HW'(1);
						state_q <= S_RESP;
					end else if (scan_end) begin
						state_q <= S_RESP;
					end else begin
						word_q  <= word_q + AW'(1);
						first_q <= 1'b0;
					end
				end
				S_FREE: begin
					if (free_hit) begin
						if (used_q != '0) begin
							used_q <= used_q - 16'd1;
						end
						if (HW'(frame_q) < hint_q) begin
							hint_q <= HW'(frame_q);
						end
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result fields of the item in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			frame_q <= idx[FW-1:0];
			faddr_q <= '0;
			if (req_free) begin
				status_q <= bpfa_pkg::ST_OUT_OF_RANGE;
			end else begin
				status_q <= bpfa_pkg::ST_NONE_FREE;
			end
		end else if (state_q == S_SCAN && fres.found) begin
			status_q <= bpfa_pkg::ST_ALLOCATED;
			faddr_q  <= 27'(faddr_wide);
		end else if (state_q == S_FREE) begin
			status_q <= free_hit ? bpfa_pkg::ST_FREED : bpfa_pkg::ST_NOT_ALLOCATED;
		end
	end

	assign used_ext  = CW'(used_q);
	assign free_wide = (limit_q > used_ext) ? (limit_q - used_ext) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_status_q <= status_q;
			m_faddr_q  <= faddr_q;
			m_used_q   <= used_q;
			m_free_q   <= free_wide[15:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_free_q, m_used_q, m_faddr_q, m_status_q};

`ifndef SYNTHESIS
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_SCAN || state_q == S_FREE))
		else $error("bitmap written outside clear, scan or free");

	a_used_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |->
		($past(state_q) == S_SCAN || $past(state_q) == S_FREE))
		else $error("used count changed outside a bitmap update");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_status_q != bpfa_pkg::ST_ALLOCATED) |-> (m_faddr_q == '0))
		else $error("frame address set on a result that allocated nothing");
`endif

endmodule
